FILE: src/utl9_pkg.sv
package utl9_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 3;

  // Lead bytes and continuation bytes of the mapped sequences
  localparam logic [ByteW-1:0] LeadEuro   = 8'd226;
  localparam logic [ByteW-1:0] EuroFirst  = 8'd130;
  localparam logic [ByteW-1:0] EuroLast   = 8'd172;
  localparam logic [ByteW-1:0] EuroCode   = 8'd164;
  localparam logic [ByteW-1:0] LeadC2     = 8'd194;
  localparam logic [ByteW-1:0] LeadC3     = 8'd195;
  localparam logic [ByteW-1:0] LeadC5     = 8'd197;
  localparam logic [ByteW-1:0] C3Offset   = 8'd64;

  // Lead thresholds: the first byte value of each longer sequence class
  localparam logic [ByteW-1:0] LeadMin    = 8'd192;
  localparam logic [ByteW-1:0] Lead3Min   = 8'd224;
  localparam logic [ByteW-1:0] Lead4Min   = 8'd240;
  localparam logic [ByteW-1:0] Lead5Min   = 8'd248;
  localparam logic [ByteW-1:0] Lead6Min   = 8'd252;
  localparam logic [ByteW-1:0] LeadBadMin = 8'd254;

  // Result of one step through the sequence tracker
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] data;
    logic             eos;
  } res_t;

  // Map a complete sequence to a Latin-9 byte; emit low when unmapped
  function automatic res_t map_seq(input logic [ByteW-1:0] lead,
                                   input logic [ByteW-1:0] first,
                                   input logic [ByteW-1:0] last);
    res_t r;
    r.emit = 1'b0;
    r.data = '0;
    r.eos  = 1'b0;
    if (lead == LeadC2) begin
      r.emit = 1'b1;
      r.data = last;
    end else if (lead == LeadC3) begin
      r.emit = 1'b1;
      r.data = last + C3Offset;
    end else if (lead == LeadC5) begin
      r.emit = 1'b1;
      case (last)
        8'd160:  r.data = 8'd166;
        8'd161:  r.data = 8'd168;
        8'd189:  r.data = 8'd180;
        8'd190:  r.data = 8'd184;
        8'd146:  r.data = 8'd188;
        8'd147:  r.data = 8'd189;
        8'd184:  r.data = 8'd190;
        default: r.emit = 1'b0;
      endcase
    end else if (lead == LeadEuro && first == EuroFirst && last == EuroLast) begin
      r.emit = 1'b1;
      r.data = EuroCode;
    end
    return r;
  endfunction

  // Continuations a lead byte calls for
  function automatic logic [CountW-1:0] cont_count(input logic [ByteW-1:0] b);
    logic [CountW-1:0] n;
    if (b < Lead3Min) begin
      n = 3'd1;
    end else if (b < Lead4Min) begin
      n = 3'd2;
    end else if (b < Lead5Min) begin
      n = 3'd3;
    end else if (b < Lead6Min) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

endpackage

FILE: src/utl9_seq.sv
module utl9_seq
  import utl9_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ByteW-1:0] byte_i,
  output res_t             res_o
);

  logic [ByteW-1:0]  lead_q,  lead_d;
  logic [CountW-1:0] need_q,  need_d;
  logic [CountW-1:0] seen_q,  seen_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic              is_cont;
  logic [CountW-1:0] seen_inc;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign seen_inc = seen_q + 3'd1;

  always_comb begin
    lead_d       = lead_q;
    need_d       = need_q;
    seen_d       = seen_q;
    first_d      = first_q;
    res_o.emit   = 1'b0;
    res_o.data   = byte_i;
    res_o.eos    = 1'b0;
    if (need_q != '0 && is_cont) begin
      seen_d = seen_inc;
      if (seen_inc == 3'd1) begin
        first_d = byte_i;
      end
      if (seen_inc >= need_q) begin
        res_o   = map_seq(lead_q, first_q, byte_i);
        lead_d  = '0;
        need_d  = '0;
        seen_d  = '0;
        first_d = '0;
      end
    end else begin
      // drop any open sequence, then take the word afresh
      lead_d  = '0;
      need_d  = '0;
      seen_d  = '0;
      first_d = '0;
      if (byte_i == '0) begin
        res_o.emit = 1'b1;
        res_o.eos  = 1'b1;
      end else if (!byte_i[7]) begin
        res_o.emit = 1'b1;
      end else if (byte_i >= LeadMin && byte_i < LeadBadMin) begin
        lead_d = byte_i;
        need_d = cont_count(byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      need_q  <= '0;
      seen_q  <= '0;
      first_q <= '0;
    end else if (adv_i) begin
      lead_q  <= lead_d;
      need_q  <= need_d;
      seen_q  <= seen_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: src/utl9_out_stage.sv
module utl9_out_stage
  import utl9_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  res_t             res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [ByteW-1:0] byte_o,
  output logic             eos_o
);

  logic             vld_q, vld_d;
  logic [ByteW-1:0] data_q;
  logic             eos_q;

  // the register can take a new word when empty or being drained
  assign free_o = !vld_q || !stall_i;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load_i && res_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i && res_i.emit) begin
      data_q <= res_i.data;
      eos_q  <= res_i.eos;
    end
  end

  assign valid_o = vld_q;
  assign byte_o  = data_q;
  assign eos_o   = eos_q;

endmodule

FILE: src/utf8_to_latin9_transcoder_core.sv
// UTF-8 to ISO-8859-15 (Latin-9) transcoder.
//
// Input channel: one UTF-8 word (in_byte_i) per handshake, taken at a rising
// edge with in_valid_i high and in_stall_o low. Output channel: one Latin-9
// word (out_byte_o, end_of_string_o) per handshake, taken with out_valid_o
// high and out_stall_i low. A word of zero ends the string: it drops any open
// sequence and comes out as zero with end_of_string_o set.
//
// Each input word yields zero or one output word. ASCII passes through; lead
// and continuation words are collected and only the mapped sequences leave.
//
// Path: a word accepted goes into the input register, and the tracker logic
// between that register and the output register maps it into the output
// register once the output register is free.
// Throughput: one word per cycle while out_stall_i stays low.
//
// Reset clears the input and output valids and the open sequence. While the
// receiver stalls, the output word holds; the input register holds its word
// too, and in_stall_o rises once both registers are full.
module utf8_to_latin9_transcoder_core
  import utl9_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             end_of_string_o
);

  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             adv;
  res_t             res;

  // advance the held word into the tracker when the output can take a result
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (!in_stall_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // sequence tracker: holds the open lead and its continuation count
  utl9_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // result register; drop words that map to nothing
  utl9_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .byte_o  (out_byte_o),
    .eos_o   (end_of_string_o)
  );

endmodule

FILE: src/utl9_checker.sv
module utl9_checker
  import utl9_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [ByteW-1:0] in_byte_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             end_of_string_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(end_of_string_o))
    else $error("stalled output word changed");

  // the terminator is always a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> out_byte_o == '0)
    else $error("end of string on non-zero word");

  // an empty output never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // an accepted terminator reaches the output when the path is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_byte_i == '0)
      ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o && end_of_string_o)
    else $error("terminator lost");

  // ASCII passes through unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_byte_i != '0 && !in_byte_i[7])
      ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o && !end_of_string_o && out_byte_o == $past(in_byte_i, 2))
    else $error("ASCII word altered");

endmodule

bind utf8_to_latin9_transcoder_core utl9_checker u_utl9_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .in_byte_i       (in_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .end_of_string_o (end_of_string_o)
);
